// File: rtl/core/grbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grbp_pkg - shared constants and helpers for the gray requantizing packer
// Widths, reset level, output queue depth, code width and divide-by-255.
// ----------------------------------------------------------------------------
package grbp_pkg;

	localparam int unsigned PIX_W      = 8;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned CW_W       = 4;   // code width 0..8
	localparam int unsigned POS_W      = 3;   // bit position in a byte
	localparam int unsigned OQ_DEPTH   = 4;
	localparam int unsigned OQ_PTR_W   = $clog2(OQ_DEPTH);
	localparam int unsigned OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

	localparam logic [PIX_W-1:0] MAX_GRAY_RST = 8'd255;

	// queue entry: packed byte and end-of-image mark
	typedef struct packed {
		logic              last;
		logic [BYTE_W-1:0] data;
	} oq_entry_t;

	// bit length of the gray level (0 for level 0)
	function automatic logic [CW_W-1:0] code_width(input logic [PIX_W-1:0] level);
		logic [CW_W-1:0] n;
		n = '0;
		for (int i = 0; i < PIX_W; i++) begin
			if (level[i]) n = CW_W'(i + 1);
		end
		return n;
	endfunction

	// floor(x / 255), exact for any product of two 8-bit values
	function automatic logic [PIX_W-1:0] div255(input logic [2*PIX_W-1:0] x);
		logic [2*PIX_W:0] t;
		logic [2*PIX_W:0] s;
		t = {1'b0, x} + 17'd1;
		s = t + (t >> 8);
		return s[2*PIX_W-1:PIX_W];
	endfunction

endpackage

// File: rtl/core/gray_requantize_bit_packer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gray_requantize_bit_packer_top - requantize gray pixels and pack the codes
// Scales each pixel to floor(pixel*max_gray_level/255) and packs the codes,
// MSB first, into a byte stream; a last pixel flushes the partial byte.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one 8-bit pixel per beat, tlast marks the final pixel of an image.
//   m_axis: one packed byte per beat, tlast on the final byte of the image.
//   cfg_wr_en/cfg_wr_data: writes max_gray_level (code width = its bit length);
//   write it only between images while the block is empty.
// Timing:
//   An input beat is taken every cycle while the queue has room for two
//   bytes. A pixel passes the input register and the scale stage; the pack
//   stage then writes its bytes into a 4-entry output queue.
//   The pack stage writes up to two bytes per cycle (a last
//   pixel that both completes a byte and leaves bits pending), the queue
//   drains one per cycle. Sustained rate: 1 pixel per cycle.
// Backpressure:
//   When the receiver stalls, the queue fills; with more than 2 entries
//   held, s_axis_tready drops and the whole pipeline holds.
// Reset:
//   arst_n clears the pipeline, the queue, the partial byte and the bit
//   position, and sets max_gray_level to 255.
// ----------------------------------------------------------------------------
module gray_requantize_bit_packer_top (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,    // max_gray_level
	// pixel input
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] pixel
	input  logic       s_axis_tlast,   // last_pixel
	// packed byte output
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] packed_byte
	output logic       m_axis_tlast    // last_byte
);

	localparam int unsigned PW  = grbp_pkg::PIX_W;
	localparam int unsigned BW  = grbp_pkg::BYTE_W;
	localparam int unsigned CWW = grbp_pkg::CW_W;
	localparam int unsigned PSW = grbp_pkg::POS_W;
	localparam int unsigned QPW = grbp_pkg::OQ_PTR_W;
	localparam int unsigned QCW = grbp_pkg::OQ_CNT_W;
	localparam int unsigned QD  = grbp_pkg::OQ_DEPTH;

	// configuration register
	logic [PW-1:0] max_gray_q;

	// stage 1: input register
	logic          vld_s1;
	logic [PW-1:0] pix_s1;
	logic          last_s1;

	// stage 2: scaled code
	logic           vld_s2;
	logic [BW-1:0]  code_s2;
	logic [CWW-1:0] width_s2;
	logic           last_s2;

	// packer state
	logic [BW-1:0]  partial_q;
	logic [PSW-1:0] bitpos_q;

	// output queue
	grbp_pkg::oq_entry_t oq_mem_q [QD];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QCW-1:0] cnt_q;

	logic adv;
	logic pop;

	// pipeline moves while the queue can take two more bytes
	assign adv           = (cnt_q <= QCW'(QD - 2));
	assign s_axis_tready = adv;
	assign pop           = m_axis_tvalid && m_axis_tready;

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gray_q <= grbp_pkg::MAX_GRAY_RST;
		end else if (cfg_wr_en) begin
			max_gray_q <= cfg_wr_data;
		end
	end

	// stage 1 and stage 2 valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
		end
	end

	// payload: capture beat, then scale
	always_ff @(posedge clk) begin
		if (adv) begin
			if (s_axis_tvalid) begin
				pix_s1  <= s_axis_tdata;
				last_s1 <= s_axis_tlast;
			end
			code_s2  <= grbp_pkg::div255(16'(pix_s1) * 16'(max_gray_q));
			width_s2 <= grbp_pkg::code_width(max_gray_q);
			last_s2  <= last_s1;
		end
	end

	// pack: place the code under the pending bits in a 16-bit window
	logic [CWW-1:0]   total;
	logic [4:0]       sh;
	logic [2*BW-1:0]  acc;
	logic             full;
	logic [BW-1:0]    nxt_part;
	logic [PSW-1:0]   nxt_pos;
	logic             flush;
	logic             push0;
	logic             push1;
	grbp_pkg::oq_entry_t ent0;
	grbp_pkg::oq_entry_t ent1;

	always_comb begin
		total    = CWW'(bitpos_q) + width_s2;
		sh       = 5'd16 - 5'(total);
		acc      = {partial_q, 8'b0} | ((2*BW)'(code_s2) << sh);
		full     = total[3];
		nxt_part = full ? acc[BW-1:0] : acc[2*BW-1:BW];
		nxt_pos  = total[PSW-1:0];
		flush    = last_s2 && (nxt_pos != '0);
		push0    = vld_s2 && adv && (full || flush);
		push1    = vld_s2 && adv && full && flush;
		ent0.data = full ? acc[2*BW-1:BW] : nxt_part;
		ent0.last = last_s2 && !(full && flush);
		ent1.data = nxt_part;
		ent1.last = 1'b1;
	end

	// packer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			bitpos_q  <= '0;
		end else if (vld_s2 && adv) begin
			partial_q <= last_s2 ? '0 : nxt_part;
			bitpos_q  <= last_s2 ? '0 : nxt_pos;
		end
	end

	// output queue storage
	always_ff @(posedge clk) begin
		if (push0) oq_mem_q[wr_ptr_q] <= ent0;
		if (push1) oq_mem_q[wr_ptr_q + QPW'(1)] <= ent1;
	end

	// output queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPW'(push0) + QPW'(push1);
			if (pop) rd_ptr_q <= rd_ptr_q + QPW'(1);
			cnt_q <= cnt_q + QCW'(push0) + QCW'(push1) - QCW'(pop);
		end
	end

	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tdata  = oq_mem_q[rd_ptr_q].data;
	assign m_axis_tlast  = oq_mem_q[rd_ptr_q].last;

endmodule

// File: dv/tb_gray_requantize_bit_packer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gray_requantize_bit_packer_top - testbench for the gray requantizing packer
// Drives pixel beats with random gaps against a randomly stalling byte sink.
// A behavioral packer tracks the gray level, the partial byte and the bit
// position and predicts every packed byte; the checker compares each output
// beat with the oldest predicted byte. Covers the default level, narrow and
// wide codes, zero level, flushes, level changes and random images.
// ----------------------------------------------------------------------------
module tb_gray_requantize_bit_packer_top;

	localparam int unsigned IDLE_LIMIT = 2000;  // cycles with no beat before giving up
	localparam int unsigned LAT_GUARD  = 8;     // pipeline settle time before a level write

	typedef struct packed {
		logic [7:0] value;
		logic       is_last;
	} packed_byte_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;   // [7:0] pixel
	logic       s_axis_tlast;   // last_pixel
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;   // [7:0] packed_byte
	logic       m_axis_tlast;   // last_byte

	// packer state as seen by the predictor
	logic [7:0] gray_level;
	logic [7:0] pack_acc;
	logic [2:0] pack_pos;

	packed_byte_t expected_bytes[$];
	int unsigned  err_count;
	int unsigned  idle_cycles;
	int unsigned  tx_gap_pct;
	int unsigned  rx_stall_pct;
	int unsigned  rx_stall_left;

	gray_requantize_bit_packer_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// number of bits needed for the gray level
	function automatic int unsigned bit_length(input logic [7:0] level);
		int unsigned n;
		n = 0;
		for (int i = 0; i < 8; i++) begin
			if (level[i]) n = i + 1;
		end
		return n;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap_len();
		if ($urandom_range(99) < 85) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// rescale one pixel, pack its code and queue the bytes it completes
	task automatic pack_pixel(input logic [7:0] pix, input logic last);
		packed_byte_t out_bytes[2];
		int unsigned  n_out;
		int unsigned  width;
		int unsigned  total;
		int unsigned  rem;
		logic [15:0]  code;
		logic [15:0]  shifted;
		n_out = 0;
		width = bit_length(gray_level);
		code  = (16'(pix) * 16'(gray_level)) / 16'd255;
		total = pack_pos + width;
		if (total >= 8) begin
			rem = total - 8;
			out_bytes[n_out] = '{value: pack_acc | 8'(code >> rem), is_last: 1'b0};
			n_out++;
			shifted  = code << (8 - rem);
			pack_acc = (rem != 0) ? shifted[7:0] : 8'h00;
			pack_pos = 3'(rem);
		end else begin
			shifted  = code << (8 - total);
			pack_acc = pack_acc | shifted[7:0];
			pack_pos = 3'(total);
		end
		// end of image: flush pending bits, mark the final byte
		if (last) begin
			if (pack_pos != 0) begin
				out_bytes[n_out] = '{value: pack_acc, is_last: 1'b0};
				n_out++;
			end
			if (n_out > 0) out_bytes[n_out-1].is_last = 1'b1;
			pack_acc = 8'h00;
			pack_pos = 3'd0;
		end
		for (int i = 0; i < n_out; i++) expected_bytes.push_back(out_bytes[i]);
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("[%0t] mismatch on %s: got 0x%02h, expected 0x%02h", $time, what, got, want);
		err_count++;
	endtask

	// send one pixel beat; tvalid stays high after acceptance
	task automatic send_pixel(input logic [7:0] pix, input logic last);
		int unsigned gap;
		gap = ($urandom_range(99) < tx_gap_pct) ? pick_gap_len() : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pix;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		pack_pixel(pix, last);
	endtask

	task automatic stop_pixels();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic wait_for_results();
		while (expected_bytes.size() != 0) @(negedge clk);
	endtask

	// level writes happen only with the pipeline drained
	task automatic set_level(input logic [7:0] level);
		stop_pixels();
		wait_for_results();
		repeat (LAT_GUARD) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= level;
		gray_level   = level;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// reset level 255: one byte per pixel, last pixel fills a byte exactly
	task automatic test_default_level();
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd1, 1'b0);
		send_pixel(8'd254, 1'b0);
		send_pixel(8'd128, 1'b1);
	endtask

	// 1-bit codes with a padded flush, then 7-bit codes where the last pixel
	// both completes a byte and leaves bits for a padded one
	task automatic test_narrow_codes();
		set_level(8'd1);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b1);
		set_level(8'd127);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd200, 1'b1);
	endtask

	// level change with bits pending, zero level adds no bits, and a last
	// pixel with nothing pending gives no byte at all
	task automatic test_zero_level();
		set_level(8'd3);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd170, 1'b0);
		send_pixel(8'd85, 1'b0);
		set_level(8'd0);
		send_pixel(8'd200, 1'b0);
		send_pixel(8'd255, 1'b1);
		send_pixel(8'd77, 1'b1);
	endtask

	// random images over a range of levels and idling patterns
	task automatic test_random_images();
		int unsigned sent;
		int unsigned img_len;
		int unsigned sel;
		logic [7:0]  pix;
		logic [7:0]  level;
		bit          paused;
		paused = 1'b0;
		for (int phase = 0; phase < 12; phase++) begin
			case (phase)
				0: level = 8'd1;
				1: level = 8'd255;
				2: level = 8'd128;
				default: level = 8'($urandom_range(1, 255));
			endcase
			set_level(level);
			case (phase)
				3: begin
					tx_gap_pct   = 0;
					rx_stall_pct = 0;
				end
				5: begin
					tx_gap_pct   = 10;
					rx_stall_pct = 60;
				end
				default: begin
					tx_gap_pct   = 25;
					rx_stall_pct = 25;
				end
			endcase
			sent = 0;
			while (sent < 90) begin
				img_len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 24);
				for (int i = 0; i < img_len; i++) begin
					sel = $urandom_range(9);
					pix = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom_range(255));
					send_pixel(pix, (i == img_len - 1));
					sent++;
					// hold the source until the sink has caught up
					if (phase == 4 && sent == 45 && !paused) begin
						paused = 1'b1;
						stop_pixels();
						wait_for_results();
					end
				end
			end
		end
	endtask

	// byte sink with random stalls
	always @(negedge clk) begin
		if (rx_stall_left > 0) begin
			rx_stall_left--;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(99) < rx_stall_pct) begin
			rx_stall_left = pick_gap_len() - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// compare each output beat with the oldest predicted byte
	always @(posedge clk) begin
		packed_byte_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch("unexpected beat", m_axis_tdata, 8'h00);
			end else begin
				want = expected_bytes.pop_front();
				if (m_axis_tdata !== want.value)
					report_mismatch("packed_byte", m_axis_tdata, want.value);
				if (m_axis_tlast !== want.is_last)
					report_mismatch("last_byte", {7'd0, m_axis_tlast}, {7'd0, want.is_last});
			end
		end
	end

	// watchdog: end the run if no beat moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d bytes outstanding",
					idle_cycles, expected_bytes.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// main sequence
	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = 8'h00;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tlast  = 1'b0;
		tx_gap_pct    = 20;
		rx_stall_pct  = 20;
		gray_level    = 8'd255;
		pack_acc      = 8'h00;
		pack_pos      = 3'd0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_level();
		test_narrow_codes();
		test_zero_level();
		test_random_images();

		stop_pixels();
		wait_for_results();
		repeat (LAT_GUARD) @(negedge clk);
		if (err_count == 0 && expected_bytes.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/grbp_pkg.sv
rtl/core/gray_requantize_bit_packer_top.sv
dv/tb_gray_requantize_bit_packer_top.sv
